// File: src/sorted_table_binary_search_core_defines.svh
// Assertion macros for the sorted table search core checks.
`ifndef SORTED_TABLE_BINARY_SEARCH_CORE_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define STBS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stbs check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define STBS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stbs check failed");

`endif

// File: src/stbs_pkg.sv
// Shared constants, types and sequencer microcode for the sorted table search core.
`default_nettype none
package stbs_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int COUNT_W         = 9;
	localparam int POS_W           = 8;
	localparam int DATA_W          = 32;
	localparam int IDX_W           = 8;

	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_SEARCH = 1'b1;

	typedef logic [1:0] step_t;

	localparam step_t STEP_IDLE  = 2'd0;
	localparam step_t STEP_START = 2'd1;
	localparam step_t STEP_PROBE = 2'd2;
	localparam step_t STEP_EMIT  = 2'd3;

	typedef enum logic [1:0] {
		COND_SEARCH,
		COND_EMPTY,
		COND_STOP,
		COND_OUT_FREE
	} cond_t;

	typedef struct packed {
		logic  in_ready;
		logic  start;
		logic  probe;
		logic  emit;
		cond_t cond;
		step_t on_true;
		step_t on_false;
	} ctrl_t;

	function automatic ctrl_t ucode(input step_t step);
		ctrl_t cw;
		cw = '{in_ready: 1'b0, start: 1'b0, probe: 1'b0, emit: 1'b0,
			cond: COND_SEARCH, on_true: STEP_IDLE, on_false: STEP_IDLE};
		unique case (step)
			STEP_IDLE: begin
				cw.in_ready = 1'b1;
				cw.cond     = COND_SEARCH;
				cw.on_true  = STEP_START;
				cw.on_false = STEP_IDLE;
			end
			STEP_START: begin
				cw.start    = 1'b1;
				cw.cond     = COND_EMPTY;
				cw.on_true  = STEP_EMIT;
				cw.on_false = STEP_PROBE;
			end
			STEP_PROBE: begin
				cw.probe    = 1'b1;
				cw.cond     = COND_STOP;
				cw.on_true  = STEP_EMIT;
				cw.on_false = STEP_PROBE;
			end
			STEP_EMIT: begin
				cw.emit     = 1'b1;
				cw.cond     = COND_OUT_FREE;
				cw.on_true  = STEP_IDLE;
				cw.on_false = STEP_EMIT;
			end
			default: begin
				cw.cond     = COND_SEARCH;
				cw.on_true  = STEP_IDLE;
				cw.on_false = STEP_IDLE;
			end
		endcase
		return cw;
	endfunction

endpackage
`default_nettype wire

// File: src/stbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module stbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: src/sorted_table_binary_search_core.sv
// Top level: sorted table store with a microcoded bisection search sequencer.
//
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  mode, position, key_or_value
// rsp       out        rsp_valid / rsp_stall  found, match_index
// cfg       in         cfg_valid / cfg_ready  element_count
//
// A write leaves the sequencer idle. A search runs start, P probes and emit,
// P at most floor(log2(TABLE_DEPTH)) + 1 (9 probes at 256).
// The single read port of the table RAM sets one probe per cycle.
// arst_n clears the sequencer, the result slot and element_count; table contents
// are undefined until written. A held rsp_stall keeps the result slot full and
// parks the sequencer before it loads the next result; req_stall is low only
// while the sequencer waits for a new item.
`default_nettype none
module sorted_table_binary_search_core #(
	parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  req_valid,
	output logic                                  req_stall,
	input  logic                                  mode,
	input  logic [stbs_pkg::POS_W-1:0]            position,
	input  logic signed [stbs_pkg::DATA_W-1:0]    key_or_value,
	output logic                                  rsp_valid,
	input  logic                                  rsp_stall,
	output logic                                  found,
	output logic [stbs_pkg::IDX_W-1:0]            match_index,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [stbs_pkg::COUNT_W-1:0]          element_count
);
	import stbs_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	step_t                     step_q;
	step_t                     step_nxt;
	ctrl_t                     cw;
	logic                      cond_hit;
	logic [COUNT_W-1:0]        count_q;
	logic [CW-1:0]             eff_count;
	logic                      out_valid_q;
	logic                      out_free;
	logic                      found_q;
	logic [IDX_W-1:0]          match_index_q;
	logic signed [DATA_W-1:0]  key_q;
	logic [CW-1:0]             lo_q;
	logic [CW-1:0]             hip1_q;
	logic [AW-1:0]             mid_q;
	logic                      res_found_q;
	logic [IDX_W-1:0]          res_idx_q;
	logic [CW-1:0]             lo_n;
	logic [CW-1:0]             hip1_n;
	logic [CW:0]               sum_cur;
	logic [CW:0]               sum_nxt;
	logic [AW-1:0]             raddr;
	logic                      take_search;
	logic                      take_write;
	logic                      empty_cur;
	logic                      hit;
	logic                      less;
	logic                      stop;
	logic [DATA_W-1:0]         rdata;
	logic signed [DATA_W-1:0]  probe_val;

	assign cw        = ucode(step_q);
	assign req_stall = !cw.in_ready;
	assign cfg_ready = 1'b1;
	assign rsp_valid = out_valid_q;
	assign found       = found_q;
	assign match_index = match_index_q;

	assign eff_count = (int'(count_q) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(count_q);

	assign take_search = cw.in_ready && req_valid && (mode == MODE_SEARCH);
	assign take_write  = cw.in_ready && req_valid && (mode == MODE_WRITE)
		&& (int'(position) < TABLE_DEPTH);

	assign probe_val = rdata;
	assign hit       = (probe_val == key_q);
	assign less      = (probe_val < key_q);
	assign lo_n      = less ? (CW'(mid_q) + CW'(1)) : lo_q;
	assign hip1_n    = less ? hip1_q : CW'(mid_q);
	assign stop      = hit || !(lo_n < hip1_n);
	assign empty_cur = !(lo_q < hip1_q);
	assign out_free  = !out_valid_q || !rsp_stall;

	assign sum_cur = {1'b0, lo_q} + {1'b0, hip1_q} - (CW + 1)'(1);
	assign sum_nxt = {1'b0, lo_n} + {1'b0, hip1_n} - (CW + 1)'(1);
	assign raddr   = cw.probe ? AW'(sum_nxt >> 1) : AW'(sum_cur >> 1);

	always_comb begin
		unique case (cw.cond)
			COND_SEARCH:   cond_hit = take_search;
			COND_EMPTY:    cond_hit = empty_cur;
			COND_STOP:     cond_hit = stop;
			COND_OUT_FREE: cond_hit = out_free;
			default:       cond_hit = 1'b0;
		endcase
		step_nxt = cond_hit ? cw.on_true : cw.on_false;
	end

	stbs_ram #(
		.WIDTH (DATA_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (take_write),
		.waddr (AW'(position)),
		.wdata (key_or_value),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_IDLE;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			step_q <= step_nxt;
			if (cfg_valid && cfg_ready) begin
				count_q <= element_count;
			end
			if (cw.emit && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_search) begin
			key_q  <= key_or_value;
			lo_q   <= '0;
			hip1_q <= eff_count;
		end
		if (cw.start || (cw.probe && !stop)) begin
			mid_q <= raddr;
		end
		if (cw.probe) begin
			lo_q        <= lo_n;
			hip1_q      <= hip1_n;
			res_found_q <= hit;
			res_idx_q   <= hit ? IDX_W'(mid_q) : '0;
		end
		if (cw.start) begin
			res_found_q <= 1'b0;
			res_idx_q   <= '0;
		end
		if (cw.emit && out_free) begin
			found_q       <= res_found_q;
			match_index_q <= res_idx_q;
		end
	end

endmodule
`default_nettype wire

// File: src/stbs_checker.sv
// Port-level checks for the sorted table search core, bound to the top level.
`default_nettype none
`include "sorted_table_binary_search_core_defines.svh"
module stbs_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  req_valid,
	input logic                                  req_stall,
	input logic                                  mode,
	input logic                                  rsp_valid,
	input logic                                  rsp_stall,
	input logic                                  found,
	input logic [stbs_pkg::IDX_W-1:0]            match_index
);
	import stbs_pkg::*;

	logic req_xfer;

	assign req_xfer = req_valid && !req_stall;

	// hold a stalled result
	`STBS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(found) && $stable(match_index))

	// a search transfer makes the block busy
	`STBS_ASSERT_NEXT(a_search_busy, req_xfer && (mode == MODE_SEARCH), req_stall)

	// a write transfer completes at once
	`STBS_ASSERT_NEXT(a_write_free, req_xfer && (mode == MODE_WRITE), !req_stall)

	// a miss reports index zero
	`STBS_ASSERT_NOW(a_miss_zero, rsp_valid && !found, match_index == '0)

endmodule

bind sorted_table_binary_search_core stbs_checker u_stbs_checker (.*);
`default_nettype wire
